### hw/rtl/mcwt_pkg.sv
// Shared types and codes for the multi-client watchdog table.
package mcwt_pkg;

  localparam int unsigned ID_W    = 23;
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned SIG_W   = 7;

  localparam logic [1:0] ACT_REGISTER = 2'd0;
  localparam logic [1:0] ACT_KICK     = 2'd1;
  localparam logic [1:0] ACT_RELEASE  = 2'd2;
  localparam logic [1:0] ACT_CHECK    = 2'd3;

  localparam logic [1:0] KIND_STATUS  = 2'd0;
  localparam logic [1:0] KIND_EXPIRED = 2'd1;
  localparam logic [1:0] KIND_DONE    = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  localparam logic REG_TIMEOUT = 1'b0;
  localparam logic REG_SIGNAL  = 1'b1;

  localparam logic [STAMP_W-1:0] TIMEOUT_RESET = 32'd60000;
  localparam logic [SIG_W-1:0]   SIGNAL_RESET  = 7'd15;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic push;
    logic kick;
    logic pull;
    logic rotate;
  } cell_ctrl_t;

endpackage

### hw/rtl/multi_client_watchdog_table.sv
// Top level of the multi-client watchdog table: control, registers and result stage.
//
//   channel   direction  handshake            payload
//   in        to block   in_valid / in_stall  action, client_id, now
//   out       from block out_valid / out_stall kind, status, expired_id, signal, last
//   cfg       to block   cfg_we               cfg_index, cfg_data
//
// Register, kick and release each give one result in the next cycle.
// A check rotates the slot chain once through its live entries, one slot per cycle
// while the output is not stalled, and then gives its done result.
// No new request is taken while a check walks the table.
// Reset is synchronous; it empties the table and restores both registers.
module multi_client_watchdog_table
  import mcwt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          action,
  input  logic [ID_W-1:0]     client_id,
  input  logic [STAMP_W-1:0]  now,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          kind,
  output logic [1:0]          status,
  output logic [ID_W-1:0]     expired_id,
  output logic [SIG_W-1:0]    signal,
  output logic                last,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [STAMP_W-1:0]  cfg_data
);

  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_WALK = 2'b10
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   walk_idx;
  logic [STAMP_W-1:0] now_q;
  logic [STAMP_W-1:0] timeout;
  logic [SIG_W-1:0]   sig_code;

  entry_t             cell_q [TABLE_DEPTH];
  logic [TABLE_DEPTH:0] seen;
  cell_ctrl_t         ctrl;
  entry_t             new_entry;

  logic accept;
  logic out_free;
  logic full;
  logic found;
  logic walk_step;
  logic at_end;
  logic [STAMP_W-1:0] age;
  logic expired;

  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = !((state == S_IDLE) && out_free);
  assign accept    = in_valid && !in_stall;
  assign full      = (count >= CNT_W'(TABLE_DEPTH));
  assign new_entry = '{id: client_id, stamp: now};

  assign walk_step = (state == S_WALK) && out_free;
  assign at_end    = (walk_idx == count);

  assign ctrl.push   = accept && (action == ACT_REGISTER) && !full;
  assign ctrl.kick   = accept && (action == ACT_KICK);
  assign ctrl.pull   = accept && (action == ACT_RELEASE);
  assign ctrl.rotate = walk_step && !at_end;

  assign seen[0] = 1'b0;
  assign found   = seen[TABLE_DEPTH];

  assign age     = now_q - cell_q[0].stamp;
  assign expired = (age > timeout);

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    entry_t left_e;
    entry_t right_e;

    if (i == 0) begin : g_first
      assign left_e = new_entry;
    end else begin : g_mid
      assign left_e = cell_q[i-1];
    end

    if (i == TABLE_DEPTH - 1) begin : g_end
      assign right_e = cell_q[i];
    end else begin : g_inner
      assign right_e = cell_q[i+1];
    end

    mcwt_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .key      (client_id),
      .now      (now),
      .live     (CNT_W'(i) < count),
      .wrap     (CNT_W'(i + 1) == count),
      .seen_in  (seen[i]),
      .left     (left_e),
      .right    (right_e),
      .head     (cell_q[0]),
      .seen_out (seen[i+1]),
      .entry    (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      walk_idx  <= '0;
      out_valid <= 1'b0;
      timeout   <= TIMEOUT_RESET;
      sig_code  <= SIGNAL_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TIMEOUT: timeout  <= cfg_data;
          REG_SIGNAL:  sig_code <= cfg_data[SIG_W-1:0];
          default: ;
        endcase
      end

      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            kind       <= KIND_STATUS;
            status     <= ST_OK;
            expired_id <= '0;
            signal     <= '0;
            last       <= 1'b1;
            case (action)
              ACT_REGISTER: begin
                out_valid <= 1'b1;
                if (full) begin
                  status <= ST_FULL;
                end else begin
                  count <= count + 1'b1;
                end
              end
              ACT_KICK: begin
                out_valid <= 1'b1;
                if (!found) begin
                  status <= ST_NOT_FOUND;
                end
              end
              ACT_RELEASE: begin
                out_valid <= 1'b1;
                if (found) begin
                  count <= count - 1'b1;
                end else begin
                  status <= ST_NOT_FOUND;
                end
              end
              ACT_CHECK: begin
                now_q    <= now;
                walk_idx <= '0;
                state    <= S_WALK;
              end
              default: ;
            endcase
          end
        end
        S_WALK: begin
          if (walk_step) begin
            if (at_end) begin
              out_valid  <= 1'b1;
              kind       <= KIND_DONE;
              status     <= ST_OK;
              expired_id <= '0;
              signal     <= '0;
              last       <= 1'b1;
              state      <= S_IDLE;
            end else begin
              walk_idx <= walk_idx + 1'b1;
              if (expired) begin
                out_valid  <= 1'b1;
                kind       <= KIND_EXPIRED;
                status     <= ST_OK;
                expired_id <= cell_q[0].id;
                signal     <= sig_code;
                last       <= 1'b0;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_DEPTH))
    else $error("entry count exceeds table depth");

  a_walk_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> in_stall)
    else $error("request taken during a check walk");

  a_walk_count_stable: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |=> $stable(count))
    else $error("entry count changed during a check walk");

  a_walk_idx_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (walk_idx <= count))
    else $error("walk index ran past the live entries");
`endif

endmodule

### hw/rtl/mcwt_cell.sv
// One table slot: holds an entry and trades it with its neighbors.
module mcwt_cell
  import mcwt_pkg::*;
(
  input  logic                clk,
  input  cell_ctrl_t          ctrl,
  input  logic [ID_W-1:0]     key,
  input  logic [STAMP_W-1:0]  now,
  input  logic                live,
  input  logic                wrap,
  input  logic                seen_in,
  input  entry_t              left,
  input  entry_t              right,
  input  entry_t              head,
  output logic                seen_out,
  output entry_t              entry
);

  logic hit;
  logic first;

  assign hit      = live && (ctrl.kick || ctrl.pull) && (entry.id == key);
  assign seen_out = seen_in || hit;
  assign first    = hit && !seen_in;

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      entry <= left;
    end else if (ctrl.kick && first) begin
      entry.stamp <= now;
    end else if (ctrl.pull && seen_out) begin
      entry <= right;
    end else if (ctrl.rotate) begin
      entry <= wrap ? head : right;
    end
  end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the multi-client watchdog table, with a built-in table predictor.
module tb;
  import mcwt_pkg::*;

  localparam int DEPTH = 16;

  typedef struct packed {
    logic [1:0]         action;
    logic [ID_W-1:0]    id;
    logic [STAMP_W-1:0] now;
  } watch_req_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [1:0]       status;
    logic [ID_W-1:0]  id;
    logic [SIG_W-1:0] sig;
    logic             last;
  } watch_res_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         action = ACT_REGISTER;
  logic [ID_W-1:0]    client_id = '0;
  logic [STAMP_W-1:0] now = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         kind;
  logic [1:0]         status;
  logic [ID_W-1:0]    expired_id;
  logic [SIG_W-1:0]   signal;
  logic               last;
  logic               cfg_we = 1'b0;
  logic               cfg_index = REG_TIMEOUT;
  logic [STAMP_W-1:0] cfg_data = '0;

  multi_client_watchdog_table dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .client_id(client_id), .now(now),
    .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .status(status), .expired_id(expired_id), .signal(signal), .last(last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  logic [ID_W-1:0]    slot_id [DEPTH];
  logic [STAMP_W-1:0] slot_stamp [DEPTH];
  int                 slot_count = 0;
  logic [STAMP_W-1:0] timeout_ticks = TIMEOUT_RESET;
  logic [SIG_W-1:0]   signal_code = SIGNAL_RESET;

  watch_req_t         pending_reqs[$];
  watch_res_t         expected_results[$];
  watch_req_t         cur_req;
  watch_res_t         due;
  int                 errors = 0;
  int                 send_idle_pct = 0;
  int                 stall_pct = 0;

  logic [ID_W-1:0]    live_ids[$];
  logic [ID_W-1:0]    id_pool [12];
  logic [STAMP_W-1:0] tick;
  int                 tick_step;

  function automatic watch_res_t make_result(logic [1:0] k, logic [1:0] st,
                                             logic [ID_W-1:0] id, logic [SIG_W-1:0] sig,
                                             logic lst);
    watch_res_t r;
    r.kind = k;
    r.status = st;
    r.id = id;
    r.sig = sig;
    r.last = lst;
    return r;
  endfunction

  function automatic void predict_watch(watch_req_t r);
    int hit;
    logic [STAMP_W-1:0] age;
    hit = -1;
    for (int i = 0; i < slot_count; i++)
      if (hit < 0 && slot_id[i] == r.id) hit = i;
    case (r.action)
      ACT_REGISTER: begin
        if (slot_count >= DEPTH) begin
          expected_results.push_back(make_result(KIND_STATUS, ST_FULL, '0, '0, 1'b1));
        end else begin
          for (int i = slot_count; i > 0; i--) begin
            slot_id[i] = slot_id[i-1];
            slot_stamp[i] = slot_stamp[i-1];
          end
          slot_id[0] = r.id;
          slot_stamp[0] = r.now;
          slot_count++;
          expected_results.push_back(make_result(KIND_STATUS, ST_OK, '0, '0, 1'b1));
        end
      end
      ACT_KICK: begin
        if (hit < 0) begin
          expected_results.push_back(make_result(KIND_STATUS, ST_NOT_FOUND, '0, '0, 1'b1));
        end else begin
          slot_stamp[hit] = r.now;
          expected_results.push_back(make_result(KIND_STATUS, ST_OK, '0, '0, 1'b1));
        end
      end
      ACT_RELEASE: begin
        if (hit < 0) begin
          expected_results.push_back(make_result(KIND_STATUS, ST_NOT_FOUND, '0, '0, 1'b1));
        end else begin
          for (int i = hit; i < slot_count - 1; i++) begin
            slot_id[i] = slot_id[i+1];
            slot_stamp[i] = slot_stamp[i+1];
          end
          slot_count--;
          expected_results.push_back(make_result(KIND_STATUS, ST_OK, '0, '0, 1'b1));
        end
      end
      default: begin
        for (int i = 0; i < slot_count; i++) begin
          age = r.now - slot_stamp[i];
          if (age > timeout_ticks)
            expected_results.push_back(make_result(KIND_EXPIRED, ST_OK, slot_id[i],
                                                   signal_code, 1'b0));
        end
        expected_results.push_back(make_result(KIND_DONE, ST_OK, '0, '0, 1'b1));
      end
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_watch(cur_req);
      if (!in_valid || !in_stall) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_req = pending_reqs.pop_front();
          in_valid <= 1'b1;
          action <= cur_req.action;
          client_id <= cur_req.id;
          now <= cur_req.now;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: result with none expected, actual kind %0h id %0h", $time, kind,
                   expired_id);
        end else begin
          due = expected_results.pop_front();
          check_field("kind", 32'(due.kind), 32'(kind));
          check_field("status", 32'(due.status), 32'(status));
          check_field("expired_id", 32'(due.id), 32'(expired_id));
          check_field("signal", 32'(due.sig), 32'(signal));
          check_field("last", 32'(due.last), 32'(last));
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic add_req(logic [1:0] act, logic [ID_W-1:0] id, logic [STAMP_W-1:0] t);
    watch_req_t r;
    int at;
    r.action = act;
    r.id = id;
    r.now = t;
    at = -1;
    pending_reqs.push_back(r);
    if (act == ACT_REGISTER && live_ids.size() < DEPTH) begin
      live_ids.push_front(id);
    end else if (act == ACT_RELEASE) begin
      for (int i = 0; i < live_ids.size(); i++)
        if (at < 0 && live_ids[i] == id) at = i;
      if (at >= 0) live_ids.delete(at);
    end
  endtask

  task automatic add_random_req();
    int pick;
    logic [ID_W-1:0] id;
    pick = $urandom_range(99);
    if ($urandom_range(9) == 0) tick = $urandom;
    else tick = tick + $urandom_range(0, tick_step);
    if ($urandom_range(3) == 0) id = ID_W'($urandom);
    else id = id_pool[$urandom_range(11)];
    if (pick < 30 - live_ids.size()) begin
      add_req(ACT_REGISTER, id, tick);
    end else if (pick < 75) begin
      if (live_ids.size() > 0 && $urandom_range(9) < 8)
        id = live_ids[$urandom_range(live_ids.size() - 1)];
      add_req(pick < 55 ? ACT_KICK : ACT_RELEASE, id, tick);
    end else begin
      add_req(ACT_CHECK, id, tick);
    end
  endtask

  task automatic drain();
    @(posedge clk);
    while (pending_reqs.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [STAMP_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_TIMEOUT) timeout_ticks = data;
    else signal_code = data[SIG_W-1:0];
  endtask

  task automatic random_phase(logic [STAMP_W-1:0] tmo, logic [STAMP_W-1:0] sig,
                              int send_pct, int stall_p, int step, int count);
    write_reg(REG_TIMEOUT, tmo);
    write_reg(REG_SIGNAL, sig);
    send_idle_pct = send_pct;
    stall_pct = stall_p;
    tick_step = step;
    repeat (count) add_random_req();
    drain();
  endtask

  initial begin
    logic [STAMP_W-1:0] t0;
    t0 = 32'hFFFF_FF00;
    foreach (id_pool[i]) id_pool[i] = ID_W'($urandom);
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Boundary cases at the reset settings: empty check, duplicates, age equal to the
    // timeout, a full table, and ages that wrap past zero.
    add_req(ACT_CHECK, '0, t0);
    add_req(ACT_REGISTER, '0, t0);
    add_req(ACT_REGISTER, '1, t0 + 10);
    add_req(ACT_REGISTER, '0, t0 + 20);
    add_req(ACT_KICK, '0, t0 + 30);
    add_req(ACT_KICK, 23'd5, t0 + 40);
    add_req(ACT_RELEASE, 23'd5, t0 + 40);
    add_req(ACT_CHECK, '0, t0 + 60000);
    add_req(ACT_CHECK, '0, t0 + 60001);
    add_req(ACT_RELEASE, '0, t0 + 60002);
    for (int i = 0; i < 14; i++) add_req(ACT_REGISTER, id_pool[i % 12], t0 + 100 + i);
    add_req(ACT_REGISTER, 23'h2AAAAA, t0 + 200);
    add_req(ACT_CHECK, '1, t0 + 70000);
    drain();

    tick = $urandom;
    random_phase('0, 32'd127, 0, 0, 3, 20);
    random_phase('1, 32'd1, 55, 0, 1000, 20);
    random_phase(32'd200, 32'd64, 0, 55, 150, 20);
    random_phase($urandom, 32'd0, 30, 30, 50000, 20);

    if (errors == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb NOT OK");
    $finish;
  end

endmodule
